### rtl/sxfp_pkg.sv
// Package for the sync/XOR frame parser.
// Holds the parse phase type, the framing bytes and the payload store depth.
// No dependencies.
package sxfp_pkg;

	localparam int unsigned STORE_DEPTH = 10;

	localparam logic [7:0] SYNC_FIRST  = 8'hFE;
	localparam logic [7:0] SYNC_SECOND = 8'h0A;
	localparam logic [7:0] TRAILER     = 8'h55;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] index_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CHECK   = 3'd3,
		PH_TRAILER = 3'd4
	} phase_t;

endpackage

### rtl/sync_xor_frame_parser_top.sv
// Sync/XOR frame parser: one received word in, one result word out per input word.
// The result is registered on accept, into the skid entry while the output is held.
// Throughput: one word per cycle while in_stall is low; a two-entry output buffer
// keeps input open while one result waits, and in_stall is high while both are full.
// Reset: asynchronous, active low; phase idle, index, XOR and payload cleared.
// Depends on sxfp_pkg.
module sync_xor_frame_parser_top #(
	parameter int unsigned PAYLOAD_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_good,
	output logic [63:0] payload_low,
	output logic [15:0] payload_high
);

	sxfp_pkg::phase_t phase_q, phase_d;
	sxfp_pkg::index_t byte_index_q, byte_index_d;
	sxfp_pkg::byte_t  xor_q, xor_d;
	sxfp_pkg::byte_t  check_q, check_d;
	sxfp_pkg::byte_t  store_q [sxfp_pkg::STORE_DEPTH];
	sxfp_pkg::byte_t  store_d [sxfp_pkg::STORE_DEPTH];
	logic             good_d;
	sxfp_pkg::index_t index_inc;

	logic        out_valid_q, skid_valid_q;
	logic        good_q, skid_good_q;
	logic [63:0] low_q, skid_low_q, low_d;
	logic [15:0] high_q, skid_high_q, high_d;

	logic accept, pop;

	assign accept    = in_valid && !in_stall;
	assign pop       = out_valid_q && !out_stall;
	assign in_stall  = skid_valid_q;
	assign index_inc = byte_index_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			sxfp_pkg::PH_IDLE: begin
				if (rx_byte == sxfp_pkg::SYNC_FIRST)
					phase_d = sxfp_pkg::PH_SYNC2;
			end
			sxfp_pkg::PH_SYNC2: begin
				if (rx_byte == sxfp_pkg::SYNC_SECOND)
					phase_d = sxfp_pkg::PH_PAYLOAD;
				else
					phase_d = sxfp_pkg::PH_IDLE;
			end
			sxfp_pkg::PH_PAYLOAD: begin
				if (index_inc >= 4'(PAYLOAD_BYTES))
					phase_d = sxfp_pkg::PH_CHECK;
			end
			sxfp_pkg::PH_CHECK:   phase_d = sxfp_pkg::PH_TRAILER;
			sxfp_pkg::PH_TRAILER: phase_d = sxfp_pkg::PH_IDLE;
			default:              phase_d = sxfp_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		byte_index_d = byte_index_q;
		xor_d        = xor_q;
		check_d      = check_q;
		good_d       = 1'b0;
		for (int k = 0; k < sxfp_pkg::STORE_DEPTH; k++)
			store_d[k] = store_q[k];
		case (phase_q)
			sxfp_pkg::PH_SYNC2: begin
				if (rx_byte == sxfp_pkg::SYNC_SECOND) begin
					byte_index_d = '0;
					xor_d        = '0;
				end
			end
			sxfp_pkg::PH_PAYLOAD: begin
				for (int k = 0; k < sxfp_pkg::STORE_DEPTH; k++)
					if (byte_index_q == 4'(k))
						store_d[k] = rx_byte;
				xor_d = xor_q ^ rx_byte;
				if (index_inc >= 4'(PAYLOAD_BYTES))
					byte_index_d = '0;
				else
					byte_index_d = index_inc;
			end
			sxfp_pkg::PH_CHECK:   check_d = rx_byte;
			sxfp_pkg::PH_TRAILER: good_d = (rx_byte == sxfp_pkg::TRAILER) && (check_q == xor_q);
			default: ;
		endcase
		for (int k = 0; k < 8; k++)
			low_d[8*k +: 8] = store_d[k];
		high_d = {store_d[9], store_d[8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sxfp_pkg::PH_IDLE;
			byte_index_q <= '0;
			xor_q        <= '0;
			check_q      <= '0;
			for (int k = 0; k < sxfp_pkg::STORE_DEPTH; k++)
				store_q[k] <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			byte_index_q <= byte_index_d;
			xor_q        <= xor_d;
			check_q      <= check_d;
			for (int k = 0; k < sxfp_pkg::STORE_DEPTH; k++)
				store_q[k] <= store_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (out_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				good_q <= skid_good_q;
				low_q  <= skid_low_q;
				high_q <= skid_high_q;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_good_q <= good_d;
				skid_low_q  <= low_d;
				skid_high_q <= high_d;
			end else begin
				good_q <= good_d;
				low_q  <= low_d;
				high_q <= high_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_good   = good_q;
	assign payload_low  = low_q;
	assign payload_high = high_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_payload_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == sxfp_pkg::PH_PAYLOAD) |=>
		(phase_q == sxfp_pkg::PH_PAYLOAD || phase_q == sxfp_pkg::PH_CHECK))
		else $error("payload phase left to an unexpected phase");

	a_check_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sxfp_pkg::PH_CHECK) |-> (byte_index_q == '0))
		else $error("byte index not cleared at check byte");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sxfp_pkg::PH_PAYLOAD) |-> (byte_index_q < 4'(PAYLOAD_BYTES)))
		else $error("payload index out of range");

endmodule
